// ----- src/jsed_pkg.sv -----
package jsed_pkg;

   // Depth of the burst queue between the front and back parts
   localparam int QueueDepth = 4;
   localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntW      = $clog2(QueueDepth + 1);

   // One decoded input item: up to three bytes plus end-of-string info
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            last;
      logic            err;
   } burst_type;

   // UTF-8 encoding limits and marker bytes
   localparam logic [15:0] Utf8Lim1  = 16'h0080;
   localparam logic [15:0] Utf8Lim2  = 16'h0800;
   localparam logic [7:0]  Utf8Lead2 = 8'hC0;
   localparam logic [7:0]  Utf8Lead3 = 8'hE0;
   localparam logic [7:0]  Utf8Cont  = 8'h80;

endpackage

// ----- src/jsed_front.sv -----
module jsed_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_in_last,
   input  logic               queue_full,
   output logic               push,
   output jsed_pkg::burst_type push_data
);
   import jsed_pkg::*;

   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_ESC,
      PH_HEX0,
      PH_HEX1,
      PH_HEX2,
      PH_HEX3
   } phase_type;

   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChSlash     = 8'h2F;
   localparam logic [7:0] ChB         = 8'h62;
   localparam logic [7:0] ChF         = 8'h66;
   localparam logic [7:0] ChN         = 8'h6E;
   localparam logic [7:0] ChR         = 8'h72;
   localparam logic [7:0] ChT         = 8'h74;
   localparam logic [7:0] ChU         = 8'h75;
   localparam logic [7:0] ChDel       = 8'h7F;
   localparam logic [7:0] ChSpace     = 8'h20;
   localparam logic [7:0] CtlBs       = 8'h08;
   localparam logic [7:0] CtlFf       = 8'h0C;
   localparam logic [7:0] CtlLf       = 8'h0A;
   localparam logic [7:0] CtlCr       = 8'h0D;
   localparam logic [7:0] CtlTab      = 8'h09;

   phase_type   phase_ff, phase_in;
   logic [15:0] hex_ff, hex_in;
   logic        err_ff, err_in;
   logic        accept;
   logic        err;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] code;
   logic [2:0][7:0] data;
   logic [1:0]  count;

   // Return {valid, digit} for one hex character
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign {hex_ok, hex_val} = hex_digit(req_in_byte);
   assign code      = {hex_ff[11:0], hex_val};

   // Classify the byte against the escape state
   always_comb begin
      err      = err_ff;
      phase_in = phase_ff;
      hex_in   = hex_ff;
      data     = '0;
      count    = 2'd0;
      if (!err_ff) begin
         case (phase_ff)
            PH_NORMAL: begin
               if (req_in_byte == ChBackslash) begin
                  phase_in = PH_ESC;
               end else if (req_in_byte < ChSpace || req_in_byte == ChDel) begin
                  err = 1'b1;
               end else begin
                  data[0] = req_in_byte;
                  count   = 2'd1;
               end
            end
            PH_ESC: begin
               phase_in = PH_NORMAL;
               count    = 2'd1;
               case (req_in_byte)
                  ChQuote, ChBackslash, ChSlash: data[0] = req_in_byte;
                  ChB: data[0] = CtlBs;
                  ChF: data[0] = CtlFf;
                  ChN: data[0] = CtlLf;
                  ChR: data[0] = CtlCr;
                  ChT: data[0] = CtlTab;
                  ChU: begin
                     count    = 2'd0;
                     phase_in = PH_HEX0;
                     hex_in   = '0;
                  end
                  default: begin
                     count = 2'd0;
                     err   = 1'b1;
                  end
               endcase
            end
            PH_HEX0, PH_HEX1, PH_HEX2: begin
               if (!hex_ok) begin
                  err      = 1'b1;
                  phase_in = PH_NORMAL;
               end else begin
                  hex_in = code;
                  case (phase_ff)
                     PH_HEX0: phase_in = PH_HEX1;
                     PH_HEX1: phase_in = PH_HEX2;
                     default: phase_in = PH_HEX3;
                  endcase
               end
            end
            PH_HEX3: begin
               phase_in = PH_NORMAL;
               hex_in   = '0;
               if (!hex_ok) begin
                  err = 1'b1;
               end else if (code < Utf8Lim1) begin
                  data[0] = code[7:0];
                  count   = 2'd1;
               end else if (code < Utf8Lim2) begin
                  data[0] = Utf8Lead2 | {3'b000, code[10:6]};
                  data[1] = Utf8Cont | {2'b00, code[5:0]};
                  count   = 2'd2;
               end else begin
                  data[0] = Utf8Lead3 | {4'b0000, code[15:12]};
                  data[1] = Utf8Cont | {2'b00, code[11:6]};
                  data[2] = Utf8Cont | {2'b00, code[5:0]};
                  count   = 2'd3;
               end
            end
            default: phase_in = PH_NORMAL;
         endcase
      end
      // Flag an escape left open at the end of the string
      if (req_in_last && !err && phase_in != PH_NORMAL) err = 1'b1;
      err_in = err;
   end

   // Queue a burst whenever the byte yields output or ends the string
   assign push           = accept && (count != 2'd0 || req_in_last);
   assign push_data.data  = data;
   assign push_data.count = count;
   assign push_data.last  = req_in_last;
   assign push_data.err   = err_in;

   // Advance the escape state; clear it at the end of a string or on error
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         hex_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         if (req_in_last || err_in) begin
            phase_ff <= PH_NORMAL;
            hex_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            hex_ff   <= hex_in;
         end
         err_ff <= req_in_last ? 1'b0 : err_in;
      end
   end

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_last |=> phase_ff == PH_NORMAL && !err_ff && hex_ff == '0)
      else $error("string end did not clear escape state");

   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> phase_ff == PH_NORMAL)
      else $error("escape still pending after error");

endmodule

// ----- src/jsed_queue.sv -----
module jsed_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsed_pkg::burst_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output jsed_pkg::burst_type head
);
   import jsed_pkg::*;

   burst_type        store_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] count_ff;

   // Step a pointer with wrap at the queue depth
   function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
      return (p == QPtrW'(QueueDepth - 1)) ? '0 : QPtrW'(p + 1'b1);
   endfunction

   assign full  = (count_ff == QCntW'(QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   // Write the tail entry
   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_data;
   end

   // Track pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         case ({push, pop})
            2'b10:   count_ff <= QCntW'(count_ff + 1'b1);
            2'b01:   count_ff <= QCntW'(count_ff - 1'b1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && empty))
      else $error("burst queue overflow or underflow");

endmodule

// ----- src/jsed_back.sv -----
module jsed_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  jsed_pkg::burst_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_run_last,
   output logic                rsp_string_done,
   output logic                rsp_decode_error
);
   import jsed_pkg::*;

   burst_type  cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   logic       rsp_valid_ff;
   logic [7:0] byte_ff;
   logic       byte_valid_ff, run_last_ff, done_ff, error_ff;
   logic [1:0] final_idx;
   logic       fin, out_load, emit, cur_free;

   // A burst with no bytes still yields one status result
   assign final_idx = (cur_ff.count == 2'd0) ? 2'd0 : 2'(cur_ff.count - 2'd1);
   assign fin       = (idx_ff == final_idx);
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = cur_valid_ff && out_load;
   assign cur_free  = !cur_valid_ff || (emit && fin);
   assign pop       = !q_empty && cur_free;

   // Hold the current burst and step through its bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= '0;
         end else if (emit && fin) begin
            cur_valid_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= 2'(idx_ff + 2'd1);
         end
         if (out_load) rsp_valid_ff <= emit;
      end
   end

   // Load the burst and the output payload
   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
      if (emit) begin
         byte_ff       <= (cur_ff.count == 2'd0) ? 8'h00 : cur_ff.data[idx_ff];
         byte_valid_ff <= (cur_ff.count != 2'd0);
         run_last_ff   <= fin;
         done_ff       <= fin && cur_ff.last;
         error_ff      <= (cur_ff.count == 2'd0) && cur_ff.err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_string_done  = done_ff;
   assign rsp_decode_error = error_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff <= final_idx)
      else $error("byte index beyond burst");

   a_error_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_decode_error |-> rsp_string_done && !rsp_byte_valid)
      else $error("error flag outside string end status");

endmodule

// ----- src/json_string_escape_decoder_core.sv -----
// Path: a byte's first result passes a queue entry, the current-burst register and the
// output register to the rsp ports; it is taken on an edge where rsp is not stalled.
// Throughput: one input byte per cycle while the queue is not full; results leave one per
// cycle unless rsp stalls; a 4-entry queue absorbs the up to 3 UTF-8 bytes of a \u escape.
// Input stalls only when the queue is full.
// Reset: synchronous, active high; clears escape state, queue and output valid.
module json_string_escape_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_done,
   output logic       rsp_decode_error
);
   import jsed_pkg::*;

   logic      push, pop, q_full, q_empty;
   burst_type push_data, head;

   jsed_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .queue_full  (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   jsed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   jsed_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_done  (rsp_string_done),
      .rsp_decode_error (rsp_decode_error)
   );

endmodule

// ----- bench/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jsed_pkg::*;

   // Decoder escape phases
   localparam logic [2:0] PhPlain  = 3'd0;
   localparam logic [2:0] PhEscape = 3'd1;
   localparam logic [2:0] PhHex0   = 3'd2;
   localparam logic [2:0] PhHex3   = 3'd5;

   // Characters with a special meaning inside a string
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChSlash     = 8'h2F;
   localparam logic [7:0] ChU         = 8'h75;
   localparam logic [7:0] ChDel       = 8'h7F;

   localparam logic [7:0][7:0] EscLetters =
      {ChQuote, ChBackslash, ChSlash, "b", "f", "n", "r", "t"};
   localparam logic [7:0][15:0] CodeEdges =
      {16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD800, 16'hDFFF};

   localparam int NumItems  = 370;
   localparam int HoldAt    = 150;
   localparam int DrainAt   = 220;
   localparam int CalmAt    = 330;
   localparam int HoldLen   = 40;
   localparam int TailWait  = 10;

   // One decoded output character as seen on the result port
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       run_last;
      logic       done;
      logic       err;
   } unesc_out_type;

   typedef struct packed {
      logic [7:0]    c;
      logic          last;
      logic          typed;
      unesc_out_type want;
   } dir_row_type;

   typedef enum {TokPlain, TokHigh, TokEscape, TokUnicode} tok_kind_type;
   typedef enum {BadControl, BadEscape, BadHex, BadTruncate} bad_kind_type;

   localparam unesc_out_type NoWant  = '0;
   localparam unesc_out_type ErrDone = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_run_last;
   logic       rsp_string_done;
   logic       rsp_decode_error;

   // Unescaper state mirrored by the testbench
   logic [2:0]  esc_phase = PhPlain;
   logic [15:0] hex_acc   = '0;
   logic        str_bad   = 1'b0;

   unesc_out_type step_out [3];
   unesc_out_type pending [$];
   dir_row_type   dir_rows [$];
   logic [7:0]    str_q [$];

   int accepted   = 0;
   int mismatches = 0;
   bit gappy      = 1'b0;
   bit calm       = 1'b0;
   bit drained    = 1'b0;
   bit held       = 1'b0;

   json_string_escape_decoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_done  (rsp_string_done),
      .rsp_decode_error (rsp_decode_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
      if (d < 4'd10) return 8'("0" + d);
      return 8'((upper ? "A" : "a") + d - 4'd10);
   endfunction

   // Map a one-letter escape to its byte; -1 when the letter is not one
   function automatic int simple_escape(input logic [7:0] c);
      case (c)
         ChQuote, ChBackslash, ChSlash: return int'(c);
         "b": return 8'h08;
         "f": return 8'h0C;
         "n": return 8'h0A;
         "r": return 8'h0D;
         "t": return 8'h09;
         default: return -1;
      endcase
   endfunction

   // Advance the unescaper by one byte; fill step_out and return the count
   function automatic int unescape_step(input logic [7:0] c, input logic last);
      logic [2:0][7:0] dec;
      logic            bad;
      int              n;
      int              h;
      n   = 0;
      dec = '0;
      bad = str_bad;
      if (!bad) begin
         if (esc_phase == PhPlain) begin
            if (c == ChBackslash) esc_phase = PhEscape;
            else if (c < 8'h20 || c == ChDel) bad = 1'b1;
            else begin
               dec[0] = c;
               n = 1;
            end
         end else if (esc_phase == PhEscape) begin
            esc_phase = PhPlain;
            h = simple_escape(c);
            if (c == ChU) begin
               esc_phase = PhHex0;
               hex_acc   = '0;
            end else if (h < 0) bad = 1'b1;
            else begin
               dec[0] = h[7:0];
               n = 1;
            end
         end else begin
            h = hex_digit(c);
            if (h < 0) begin
               bad       = 1'b1;
               esc_phase = PhPlain;
            end else begin
               hex_acc = {hex_acc[11:0], h[3:0]};
               if (esc_phase == PhHex3) begin
                  // Encode the code unit as UTF-8
                  if (hex_acc < Utf8Lim1) begin
                     dec[0] = hex_acc[7:0];
                     n = 1;
                  end else if (hex_acc < Utf8Lim2) begin
                     dec[0] = Utf8Lead2 | {3'b000, hex_acc[10:6]};
                     dec[1] = Utf8Cont | {2'b00, hex_acc[5:0]};
                     n = 2;
                  end else begin
                     dec[0] = Utf8Lead3 | {4'b0000, hex_acc[15:12]};
                     dec[1] = Utf8Cont | {2'b00, hex_acc[11:6]};
                     dec[2] = Utf8Cont | {2'b00, hex_acc[5:0]};
                     n = 3;
                  end
                  esc_phase = PhPlain;
                  hex_acc   = '0;
               end else esc_phase = esc_phase + 3'd1;
            end
         end
      end
      if (last && !bad && esc_phase != PhPlain) bad = 1'b1;
      for (int k = 0; k < n; k++) begin
         step_out[k] = '{dec[k], 1'b1, k == n - 1, (k == n - 1) && last, 1'b0};
      end
      if (last) begin
         if (n == 0) begin
            step_out[0] = '{8'h00, 1'b0, 1'b1, 1'b1, bad};
            n = 1;
         end
         esc_phase = PhPlain;
         hex_acc   = '0;
         str_bad   = 1'b0;
      end else begin
         str_bad = bad;
         if (bad) begin
            esc_phase = PhPlain;
            hex_acc   = '0;
         end
      end
      return n;
   endfunction

   // Offer one item, wait for it to be taken, then queue its decoded bytes
   task automatic send_byte(input logic [7:0] c, input logic last, input logic typed,
                            input unesc_out_type want);
      int n;
      if (gappy && !calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= c;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = unescape_step(c, last);
      if (typed) pending.push_back(want);
      else for (int k = 0; k < n; k++) pending.push_back(step_out[k]);
      accepted++;
      @(negedge clock);
   endtask

   task automatic push_hex(input int digits);
      repeat (digits)
         str_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
   endtask

   // Build one string: mostly well formed, some with a single defect plus noise
   task automatic build_string();
      int           tokens;
      int           bad_at;
      int           r;
      bit           broken;
      tok_kind_type tok;
      bad_kind_type bad;
      logic [7:0]   b;
      logic [15:0]  v;
      str_q.delete();
      tokens = $urandom_range(1, 10);
      broken = ($urandom_range(0, 99) < 15);
      bad_at = $urandom_range(0, tokens - 1);
      for (int t = 0; t < tokens; t++) begin
         if (broken && t == bad_at) begin
            bad = bad_kind_type'($urandom_range(0, 3));
            case (bad)
               BadControl: begin
                  b = 8'($urandom_range(0, 8'h20));
                  str_q.push_back(b == 8'h20 ? ChDel : b);
               end
               BadEscape: begin
                  str_q.push_back(ChBackslash);
                  do b = 8'($urandom_range(0, 255));
                  while (simple_escape(b) >= 0 || b == ChU);
                  str_q.push_back(b);
               end
               BadHex: begin
                  str_q.push_back(ChBackslash);
                  str_q.push_back(ChU);
                  push_hex($urandom_range(0, 3));
                  do b = 8'($urandom_range(0, 255));
                  while (hex_digit(b) >= 0);
                  str_q.push_back(b);
               end
               BadTruncate: begin
                  // End the string in the middle of an escape
                  str_q.push_back(ChBackslash);
                  if ($urandom_range(0, 1)) begin
                     str_q.push_back(ChU);
                     push_hex($urandom_range(0, 3));
                  end
                  break;
               end
            endcase
            repeat ($urandom_range(0, 4)) str_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            r = $urandom_range(0, 99);
            tok = (r < 30) ? TokPlain : (r < 45) ? TokHigh : (r < 65) ? TokEscape : TokUnicode;
            case (tok)
               TokPlain: begin
                  b = 8'($urandom_range(8'h20, 8'h7E));
                  if (b == ChBackslash) str_q.push_back(ChBackslash);
                  str_q.push_back(b);
               end
               TokHigh: str_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
               TokEscape: begin
                  str_q.push_back(ChBackslash);
                  str_q.push_back(EscLetters[3'($urandom_range(0, 7))]);
               end
               TokUnicode: begin
                  case ($urandom_range(0, 3))
                     0: v = 16'($urandom_range(0, 16'h7F));
                     1: v = 16'($urandom_range(16'h80, 16'h7FF));
                     2: v = 16'($urandom_range(16'h800, 16'hFFFF));
                     default: v = CodeEdges[3'($urandom_range(0, 7))];
                  endcase
                  str_q.push_back(ChBackslash);
                  str_q.push_back(ChU);
                  for (int d = 3; d >= 0; d--) begin
                     str_q.push_back(hex_char(v[d*4 +: 4], 1'($urandom_range(0, 1))));
                  end
               end
            endcase
         end
      end
   endtask

   // Stimulus: reset, directed table, then random strings
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = '0;
      req_in_last = 1'b0;

      dir_rows.push_back('{"a",         1'b0, 1'b1, '{8'h61, 1'b1, 1'b1, 1'b0, 1'b0}});
      dir_rows.push_back('{8'hFF,       1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0}});
      dir_rows.push_back('{ChBackslash, 1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"n",         1'b0, 1'b1, '{8'h0A, 1'b1, 1'b1, 1'b0, 1'b0}});
      // \u0000 gives a real NUL byte
      dir_rows.push_back('{ChBackslash, 1'b0, 1'b0, NoWant});
      dir_rows.push_back('{ChU,         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"0",         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"0",         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"0",         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"0",         1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}});
      // \uFfFf gives the widest three-byte burst
      dir_rows.push_back('{ChBackslash, 1'b0, 1'b0, NoWant});
      dir_rows.push_back('{ChU,         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"F",         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"f",         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"F",         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"f",         1'b0, 1'b0, NoWant});
      // unknown escape, then a dropped byte ends the string
      dir_rows.push_back('{ChBackslash, 1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"q",         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"x",         1'b1, 1'b1, ErrDone});
      // raw control bytes and an end right after a backslash
      dir_rows.push_back('{ChDel,       1'b1, 1'b1, ErrDone});
      dir_rows.push_back('{8'h00,       1'b1, 1'b1, ErrDone});
      dir_rows.push_back('{ChBackslash, 1'b1, 1'b1, ErrDone});
      // bad hex digit on the last byte
      dir_rows.push_back('{ChBackslash, 1'b0, 1'b0, NoWant});
      dir_rows.push_back('{ChU,         1'b0, 1'b0, NoWant});
      dir_rows.push_back('{"g",         1'b1, 1'b1, ErrDone});
      dir_rows.push_back('{8'h20,       1'b1, 1'b1, '{8'h20, 1'b1, 1'b1, 1'b1, 1'b0}});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].c, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
      end

      while (accepted < NumItems) begin
         build_string();
         gappy = 1'($urandom_range(0, 1));
         calm  = (accepted >= CalmAt);
         // Once mid-run, hold the input until the output has caught up
         if (!drained && accepted >= DrainAt) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending.size() != 0) @(negedge clock);
         end
         foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1, 1'b0, NoWant);
      end
      req_valid <= 1'b0;

      while (pending.size() != 0) @(negedge clock);
      repeat (TailWait) @(negedge clock);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // Output stall: random bursts, one long hold-off, quiet at the end
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (calm) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else if (!held && accepted >= HoldAt) begin
            // Long hold so the queue fills and the input backs up
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HoldLen) @(negedge clock);
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Compare every taken item with the oldest expected character
   always @(posedge clock) begin
      unesc_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            $display("%0t: unexpected item, expected none actual byte %02h", $time,
                     rsp_out_byte);
            mismatches++;
         end else begin
            want = pending.pop_front();
            check_field("out_byte", want.data, rsp_out_byte);
            check_field("byte_valid", 8'(want.valid), 8'(rsp_byte_valid));
            check_field("run_last", 8'(want.run_last), 8'(rsp_run_last));
            check_field("string_done", 8'(want.done), 8'(rsp_string_done));
            check_field("decode_error", 8'(want.err), 8'(rsp_decode_error));
         end
      end
   end

   initial begin
      #200_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
src/jsed_pkg.sv
src/jsed_front.sv
src/jsed_queue.sv
src/jsed_back.sv
src/json_string_escape_decoder_core.sv
bench/tb.sv
